[src/lzss_pkg.sv]
// lzss_pkg: widths, register indexes, reset values and state encodings
// for the lzss stream decompressor; depends on nothing
package lzss_pkg;

   localparam int LZSS_WINDOW_SIZE = 4096;

   localparam int BYTE_W     = 8;
   localparam int NIBBLE_W   = 4;
   localparam int POS_W      = 12;
   localparam int RUN_W      = 5;
   localparam int FLAGS_W    = 4;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 12;

   localparam logic [RUN_W-1:0]   MATCH_MIN    = RUN_W'(3);
   localparam logic [FLAGS_W-1:0] FLAGS_PER_GROUP = FLAGS_W'(8);

   localparam logic [CSR_IDX_W-1:0] CSR_FILL_VALUE     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_START_POSITION = CSR_IDX_W'(1);

   localparam logic [BYTE_W-1:0] FILL_RESET  = 8'h00;
   localparam logic [POS_W-1:0]  START_RESET = 12'hFEE;

   typedef enum logic [2:0] {
      PH_FLAG       = 3'b001,
      PH_TOKEN      = 3'b010,
      PH_MATCH_HIGH = 3'b100
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_COPY = 2'b10
   } state_type;

endpackage

[src/lzss_stream_decompressor.sv]
// lzss_stream_decompressor: lzss decoder with a history window in one ram
// depends on lzss_pkg and lzss_ram
//
//   port group  direction  content
//   req_*       in         compressed byte, end of stream mark
//   rsp_*       out        decompressed byte, last byte of the run
//   csr_*       in         fill value and start position writes
//
// flag byte, literal and match low byte: one req transfer each
// match: high byte, then one copied byte (3 to 18) per cycle
// unless rsp stalls, set by the single window read and write per byte
// window contents tracked by a fill count from the stream start position,
// so no clearing pass is needed after reset or at stream end
// an rsp stall holds the copy and stalls req
module lzss_stream_decompressor
   import lzss_pkg::*;
#(
   parameter int WINDOW_SIZE = LZSS_WINDOW_SIZE
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [BYTE_W-1:0]     req_in_byte,
   input  logic                  req_end_of_stream,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [BYTE_W-1:0]     rsp_out_byte,
   output logic                  rsp_run_last,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int AW = $clog2(WINDOW_SIZE);
   localparam int CW = AW + 1;
   localparam logic [CW-1:0] CNT_FULL = CW'(WINDOW_SIZE);

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;

   logic [BYTE_W-1:0]  flag_bits_ff, flag_bits_in;
   logic [FLAGS_W-1:0] flags_left_ff, flags_left_in;
   logic [BYTE_W-1:0]  low_ff, low_in;
   logic               stream_open_ff, stream_open_in;
   logic               eos_pend_ff, eos_pend_in;

   logic [BYTE_W-1:0]  csr_fill_ff, csr_fill_in;
   logic [POS_W-1:0]   csr_start_ff, csr_start_in;
   logic [BYTE_W-1:0]  active_fill_ff, active_fill_in;
   logic [AW-1:0]      base_ff, base_in;
   logic [AW-1:0]      wp_ff, wp_in;
   logic [CW-1:0]      count_ff, count_in;

   logic [AW-1:0]      src_ff, src_in;
   logic [RUN_W-1:0]   remain_ff, remain_in;
   logic               fwd_ff, fwd_in;
   logic [BYTE_W-1:0]  fwd_data_ff, fwd_data_in;
   logic               hit_ff, hit_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  rsp_byte_ff, rsp_byte_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [BYTE_W-1:0]  ram_wdata;
   logic [AW-1:0]      ram_raddr;
   logic [BYTE_W-1:0]  ram_rdata;

   logic               req_take;
   logic               out_free;
   logic               begin_req;
   logic [POS_W-1:0]   match_pos;
   logic [AW-1:0]      rd_off;
   logic [BYTE_W-1:0]  rd_val;

   lzss_ram #(
      .DATA_W (BYTE_W),
      .DEPTH  (WINDOW_SIZE)
   ) u_window (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign req_take  = req_valid && !req_stall;
   assign match_pos = {req_in_byte[BYTE_W-1 -: NIBBLE_W], low_ff};
   assign rd_val    = fwd_ff ? fwd_data_ff : (hit_ff ? ram_rdata : active_fill_ff);
   assign rd_off    = ram_raddr - base_ff;

   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      flag_bits_in   = flag_bits_ff;
      flags_left_in  = flags_left_ff;
      low_in         = low_ff;
      stream_open_in = stream_open_ff;
      eos_pend_in    = eos_pend_ff;
      csr_fill_in    = csr_fill_ff;
      csr_start_in   = csr_start_ff;
      active_fill_in = active_fill_ff;
      base_in        = base_ff;
      wp_in          = wp_ff;
      count_in       = count_ff;
      src_in         = src_ff;
      remain_in      = remain_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_byte_in    = rsp_byte_ff;
      rsp_last_in    = rsp_last_ff;
      ram_we         = 1'b0;
      ram_waddr      = wp_ff;
      ram_wdata      = req_in_byte;
      ram_raddr      = src_ff;
      begin_req      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            ram_raddr = match_pos[AW-1:0];
            if (req_take) begin
               stream_open_in = 1'b1;
               case (phase_ff)
                  PH_FLAG: begin
                     flag_bits_in  = req_in_byte;
                     flags_left_in = FLAGS_PER_GROUP;
                     phase_in      = PH_TOKEN;
                  end
                  PH_TOKEN: begin
                     if (flag_bits_ff[0]) begin
                        // literal
                        ram_we        = 1'b1;
                        rsp_valid_in  = 1'b1;
                        rsp_byte_in   = req_in_byte;
                        rsp_last_in   = 1'b1;
                        wp_in         = wp_ff + AW'(1);
                        count_in      = (count_ff == CNT_FULL) ? count_ff : count_ff + CW'(1);
                        flag_bits_in  = flag_bits_ff >> 1;
                        flags_left_in = (flags_left_ff != '0) ? flags_left_ff - FLAGS_W'(1)
                                                              : flags_left_ff;
                        phase_in      = (flags_left_in == '0) ? PH_FLAG : PH_TOKEN;
                     end else begin
                        low_in   = req_in_byte;
                        phase_in = PH_MATCH_HIGH;
                     end
                  end
                  PH_MATCH_HIGH: begin
                     src_in      = match_pos[AW-1:0];
                     remain_in   = MATCH_MIN + RUN_W'(req_in_byte[NIBBLE_W-1:0]);
                     eos_pend_in = req_end_of_stream;
                     state_in    = ST_COPY;
                  end
                  default: begin
                     phase_in = PH_FLAG;
                  end
               endcase
               if (req_end_of_stream && (phase_ff != PH_MATCH_HIGH)) begin
                  begin_req = 1'b1;
               end
            end
         end
         ST_COPY: begin
            if (out_free) begin
               // one match byte: write back, emit, read the next source
               ram_raddr    = src_ff + AW'(1);
               ram_we       = 1'b1;
               ram_wdata    = rd_val;
               rsp_valid_in = 1'b1;
               rsp_byte_in  = rd_val;
               rsp_last_in  = (remain_ff == RUN_W'(1));
               wp_in        = wp_ff + AW'(1);
               count_in     = (count_ff == CNT_FULL) ? count_ff : count_ff + CW'(1);
               src_in       = src_ff + AW'(1);
               remain_in    = remain_ff - RUN_W'(1);
               if (remain_ff == RUN_W'(1)) begin
                  state_in      = ST_IDLE;
                  flag_bits_in  = flag_bits_ff >> 1;
                  flags_left_in = (flags_left_ff != '0) ? flags_left_ff - FLAGS_W'(1)
                                                        : flags_left_ff;
                  phase_in      = (flags_left_in == '0) ? PH_FLAG : PH_TOKEN;
                  if (eos_pend_ff) begin
                     begin_req = 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_write_enable) begin
         if (csr_index == CSR_FILL_VALUE) begin
            csr_fill_in = csr_write_data[BYTE_W-1:0];
            if (!stream_open_ff) begin
               begin_req = 1'b1;
            end
         end else if (csr_index == CSR_START_POSITION) begin
            csr_start_in = csr_write_data[POS_W-1:0];
            if (!stream_open_ff) begin
               begin_req = 1'b1;
            end
         end
      end

      if (begin_req) begin
         active_fill_in = csr_fill_in;
         base_in        = csr_start_in[AW-1:0];
         wp_in          = csr_start_in[AW-1:0];
         count_in       = '0;
         flag_bits_in   = '0;
         flags_left_in  = '0;
         phase_in       = PH_FLAG;
         low_in         = '0;
         stream_open_in = 1'b0;
      end
   end

   // read-during-write forwarding and window fill check for the issued read
   assign fwd_in      = ram_we && (ram_waddr == ram_raddr);
   assign fwd_data_in = ram_wdata;
   assign hit_in      = ({1'b0, rd_off} < count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         phase_ff       <= PH_FLAG;
         flag_bits_ff   <= '0;
         flags_left_ff  <= '0;
         low_ff         <= '0;
         stream_open_ff <= 1'b0;
         eos_pend_ff    <= 1'b0;
         csr_fill_ff    <= FILL_RESET;
         csr_start_ff   <= START_RESET;
         active_fill_ff <= FILL_RESET;
         base_ff        <= START_RESET[AW-1:0];
         wp_ff          <= START_RESET[AW-1:0];
         count_ff       <= '0;
         fwd_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         phase_ff       <= phase_in;
         flag_bits_ff   <= flag_bits_in;
         flags_left_ff  <= flags_left_in;
         low_ff         <= low_in;
         stream_open_ff <= stream_open_in;
         eos_pend_ff    <= eos_pend_in;
         csr_fill_ff    <= csr_fill_in;
         csr_start_ff   <= csr_start_in;
         active_fill_ff <= active_fill_in;
         base_ff        <= base_in;
         wp_ff          <= wp_in;
         count_ff       <= count_in;
         fwd_ff         <= fwd_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff      <= src_in;
      remain_ff   <= remain_in;
      fwd_data_ff <= fwd_data_in;
      hit_ff      <= hit_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_run_last = rsp_last_ff;

`ifndef SYNTHESIS
   a_no_req_during_copy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COPY) |-> req_stall)
      else $error("req transfer possible during match copy");

   a_copy_ends_with_last: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_COPY) && (state_in == ST_IDLE)) |=> (rsp_valid && rsp_run_last))
      else $error("match copy ended without a last byte");

   a_fill_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("window fill count beyond window size");

   a_token_has_flags: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_FLAG) |-> (flags_left_ff != '0))
      else $error("token expected with no flags left");
`endif

endmodule

[src/lzss_ram.sv]
// lzss_ram: generic single write port, single read port ram
// with registered read data; no dependencies
module lzss_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
